@@ rtl/core/tlb_pkg.sv @@
// Shared constants, types and constant tables for the throttle LED bar renderer.
// Depends on nothing; used by tlb_seq, tlb_pipe and throttle_led_bar_render.
package tlb_pkg;

  localparam int LED_COUNT = 12;
  localparam int LED_M     = LED_COUNT - 1;
  localparam int IDX_W     = $clog2(LED_COUNT);
  localparam int POS_W     = $clog2(256 * LED_COUNT + 1);
  localparam int FILL_W    = 9;
  localparam int PULSE_W   = 9;
  localparam int PROD1_W   = 8 + FILL_W;
  localparam int PROD2_W   = PROD1_W + PULSE_W;
  localparam int MAG_MAX   = 127;
  localparam int PULSE_ONE = 256;

  typedef logic [POS_W-1:0] pos_tab_t [128];
  typedef logic [PULSE_W-1:0] breath_tab_t [256];
  typedef logic [7:0] byte_tab_t [256];
  typedef logic [7:0] base_tab_t [LED_COUNT];

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [POS_W-1:0]   pos;
    logic [PULSE_W-1:0] pulse;
    logic               rev;
  } tlb_item_t;

  localparam logic [7:0] QUARTER_SINE [65] = '{
    8'd0, 8'd3, 8'd6, 8'd9, 8'd12, 8'd16, 8'd19, 8'd22,
    8'd25, 8'd28, 8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46,
    8'd49, 8'd51, 8'd54, 8'd57, 8'd60, 8'd63, 8'd65, 8'd68,
    8'd71, 8'd73, 8'd76, 8'd78, 8'd81, 8'd83, 8'd85, 8'd88,
    8'd90, 8'd92, 8'd94, 8'd96, 8'd98, 8'd100, 8'd102, 8'd104,
    8'd106, 8'd107, 8'd109, 8'd111, 8'd112, 8'd113, 8'd115, 8'd116,
    8'd117, 8'd118, 8'd120, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124,
    8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127,
    8'd127
  };

  function automatic pos_tab_t build_pos();
    pos_tab_t t;
    int m;
    for (m = 0; m < 128; m++) begin
      if (m == 0) begin
        t[m] = '0;
      end else begin
        t[m] = POS_W'((256 * (126 + 59 * (m - 1)) * LED_COUNT) / (630 * 12));
      end
    end
    return t;
  endfunction

  function automatic breath_tab_t build_breath();
    breath_tab_t t;
    int p;
    for (p = 0; p < 256; p++) begin
      if (p <= 64) begin
        t[p] = PULSE_W'(128 + int'(QUARTER_SINE[p]));
      end else if (p <= 128) begin
        t[p] = PULSE_W'(128 + int'(QUARTER_SINE[128 - p]));
      end else if (p <= 192) begin
        t[p] = PULSE_W'(128 - int'(QUARTER_SINE[p - 128]));
      end else begin
        t[p] = PULSE_W'(128 - int'(QUARTER_SINE[256 - p]));
      end
    end
    return t;
  endfunction

  function automatic byte_tab_t build_gamma();
    byte_tab_t t;
    int v;
    for (v = 0; v < 256; v++) begin
      t[v] = 8'((v * v) / 255);
    end
    return t;
  endfunction

  function automatic base_tab_t build_red();
    base_tab_t t;
    int i;
    for (i = 0; i < LED_COUNT; i++) begin
      t[i] = (2 * i < LED_M) ? 8'((510 * i) / LED_M) : 8'd255;
    end
    return t;
  endfunction

  function automatic base_tab_t build_green();
    base_tab_t t;
    int i;
    for (i = 0; i < LED_COUNT; i++) begin
      t[i] = (2 * i < LED_M) ? 8'd255 : 8'((255 * (2 * LED_M - 2 * i)) / LED_M);
    end
    return t;
  endfunction

  localparam pos_tab_t    POS_TABLE    = build_pos();
  localparam breath_tab_t BREATH_TABLE = build_breath();
  localparam byte_tab_t   GAMMA_TABLE  = build_gamma();
  localparam base_tab_t   RED_TABLE    = build_red();
  localparam base_tab_t   GREEN_TABLE  = build_green();

endpackage

@@ rtl/core/tlb_seq.sv @@
// Frame sequencer: takes one input transfer, derives lit length and pulse,
// then issues one LED index per cycle while item_ready is high. Depends on tlb_pkg.
module tlb_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           speed,
  input  logic                 reverse,
  input  logic [7:0]           pulse_phase,
  output logic                 item_valid,
  input  logic                 item_ready,
  output tlb_pkg::tlb_item_t   item
);
  import tlb_pkg::*;

  logic                 busy;
  logic [IDX_W-1:0]     idx;
  logic [POS_W-1:0]     pos;
  logic [PULSE_W-1:0]   pulse;
  logic                 rev;
  logic [6:0]           mag;
  logic [7:0]           neg;
  logic                 advance;
  logic                 last_idx;
  logic                 take;

  assign neg      = 8'd0 - speed;
  assign mag      = speed[7] ? ((speed == 8'h80) ? 7'(MAG_MAX) : neg[6:0]) : speed[6:0];
  assign advance  = busy && item_ready;
  assign last_idx = (idx == IDX_W'(LED_M));
  assign in_ready = !busy || (advance && last_idx);
  assign take     = in_valid && in_ready;

  assign item_valid = busy;
  assign item       = '{idx: idx, pos: pos, pulse: pulse, rev: rev};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (advance) begin
      if (last_idx) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pos   <= POS_TABLE[mag];
      pulse <= (mag == 7'(MAG_MAX)) ? BREATH_TABLE[pulse_phase] : PULSE_W'(PULSE_ONE);
      rev   <= reverse;
    end
  end

endmodule

@@ rtl/core/tlb_pipe.sv @@
// Color datapath: fill and base color, fill scaling, pulse scaling, gamma.
// Four registered stages with valid bits and backpressure. Depends on tlb_pkg.
module tlb_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlb_pkg::tlb_item_t   item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           led_index,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic                 last
);
  import tlb_pkg::*;

  logic                 v1, v2, v3, v4;
  logic                 r1, r2, r3, r4;

  logic [3:0]           s1_led;
  logic                 s1_last;
  logic [7:0]           s1_red, s1_grn;
  logic [FILL_W-1:0]    s1_fill;
  logic [PULSE_W-1:0]   s1_pulse;

  logic [3:0]           s2_led;
  logic                 s2_last;
  logic [PROD1_W-1:0]   s2_red, s2_grn;
  logic [PULSE_W-1:0]   s2_pulse;

  logic [3:0]           s3_led;
  logic                 s3_last;
  logic [7:0]           s3_red, s3_grn;

  logic [POS_W-1:0]     base;
  logic [POS_W-1:0]     diff;
  logic [FILL_W-1:0]    fill;
  logic [IDX_W-1:0]     phys;
  logic [PROD2_W-1:0]   red_p, grn_p;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign base = POS_W'({item.idx, 8'd0});
  assign diff = item.pos - base;
  assign phys = item.rev ? (IDX_W'(LED_M) - item.idx) : item.idx;

  always_comb begin
    if (item.pos <= base) begin
      fill = '0;
    end else if (diff >= POS_W'(256)) begin
      fill = FILL_W'(256);
    end else begin
      fill = FILL_W'(diff);
    end
  end

  assign red_p = PROD2_W'(s2_red) * PROD2_W'(s2_pulse);
  assign grn_p = PROD2_W'(s2_grn) * PROD2_W'(s2_pulse);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_led   <= 4'(phys);
      s1_last  <= (item.idx == IDX_W'(LED_M));
      s1_red   <= RED_TABLE[item.idx];
      s1_grn   <= GREEN_TABLE[item.idx];
      s1_fill  <= fill;
      s1_pulse <= item.pulse;
    end
    if (r2) begin
      s2_led   <= s1_led;
      s2_last  <= s1_last;
      s2_red   <= PROD1_W'(s1_red) * PROD1_W'(s1_fill);
      s2_grn   <= PROD1_W'(s1_grn) * PROD1_W'(s1_fill);
      s2_pulse <= s1_pulse;
    end
    if (r3) begin
      s3_led  <= s2_led;
      s3_last <= s2_last;
      s3_red  <= red_p[23:16];
      s3_grn  <= grn_p[23:16];
    end
    if (r4) begin
      led_index <= s3_led;
      last      <= s3_last;
      red       <= GAMMA_TABLE[s3_red];
      green     <= GAMMA_TABLE[s3_grn];
    end
  end

  assign out_valid = v4;

endmodule

@@ rtl/core/throttle_led_bar_render.sv @@
// Top level of the throttle LED bar renderer: stream ports, sequencer, datapath.
// Depends on tlb_pkg, tlb_seq and tlb_pipe.
//
//   channel  dir  tdata (low bit up)                         side band
//   s_*      in   speed[7:0], pulse_phase[15:8]              tuser = reverse
//   m_*      out  led_index[3:0], red[11:4], green[19:12],   tlast = last LED
//                 zero[31:20]
//
// Each input transfer yields LED_COUNT output transfers, one per cycle unless m_tready
// stalls; a new input is taken as the sequencer's index counter issues its last index.
// First result passes the sequencer and then the four stages.
// rst clears the sequencer and all stage valid bits; no other state.
// A stall on m_tready backs up the stages in place; nothing is lost or repeated.
module throttle_led_bar_render (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // speed, pulse_phase
  input  logic        s_tuser,   // reverse
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // led_index, red, green, zero pad
  output logic        m_tlast
);
  import tlb_pkg::*;

  tlb_item_t   item;
  logic        item_valid;
  logic        item_ready;
  logic [3:0]  led_index;
  logic [7:0]  red;
  logic [7:0]  green;

  tlb_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .speed       (s_tdata[7:0]),
    .reverse     (s_tuser),
    .pulse_phase (s_tdata[15:8]),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  tlb_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .item      (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .last      (m_tlast)
  );

  assign m_tdata = {4'd0, 8'd0, green, red, led_index};

endmodule
